FILE: rtl/htfd_pkg.sv
// Shared types, constants and functions of the humidity/temperature frame decoder.
`default_nettype none

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY       = 8'h31;
    localparam logic [7:0]  CRC_INIT       = 8'hFF;

    // Fixed-point scale factors: humidity = floor(100*raw/65535),
    // temperature tenths = floor(1750*raw/65535) - 450.
    localparam logic [6:0]  HUM_SCALE      = 7'd100;
    localparam logic [10:0] TEMP_SCALE     = 11'd1750;
    localparam logic [10:0] TEMP_OFFSET    = 11'd450;
    localparam logic [10:0] ROUND_HALF     = 11'd5;
    // floor(v/10) == (v*6554)>>16 for v below 16384
    localparam logic [12:0] RECIP_TEN      = 13'd6554;
    localparam logic [6:0]  DEG_MAX        = 7'd127;

    localparam logic [6:0]  TEMP_LIMIT_RST  = 7'd50;
    localparam logic [6:0]  HUMID_LIMIT_RST = 7'd100;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        CFG_TEMP_LIMIT  = 2'd0,
        CFG_HUMID_LIMIT = 2'd1
    } cfg_index_t;

    // Role of a byte inside the six-byte frame
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef struct packed {
        logic [7:0] data;
        pos_t       pos;
    } htfd_item_t;

    typedef struct packed {
        logic [6:0] temp_limit;
        logic [6:0] humid_limit;
    } htfd_limits_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Report a held value in 1..limit; a zero limit acts as 1.
    function automatic logic [6:0] clamp_out(input logic [6:0] v, input logic [6:0] limit);
        logic [6:0] lim;
        logic [6:0] val;
        lim = (limit == 7'd0) ? 7'd1 : limit;
        val = (v == 7'd0) ? 7'd1 : v;
        return (val > lim) ? lim : val;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/htfd_front.sv
// Front end: accept frame bytes and tag each with its position in the frame.
`default_nettype none

module htfd_front
    import htfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       s_tuser,   // [0] frame_start
    input  wire logic       q_full,
    output logic            push,
    output htfd_item_t      push_item
);

    pos_t pos_reg;
    pos_t pos_next;
    pos_t pos_cur;

    always_comb
    begin
        s_tready = !q_full;
        push     = s_tvalid && s_tready;
        pos_cur  = s_tuser ? POS_T_HI : pos_reg;
        push_item.data = s_tdata;
        push_item.pos  = pos_cur;
        case (pos_cur)
            POS_T_HI:  pos_next = POS_T_LO;
            POS_T_LO:  pos_next = POS_T_CRC;
            POS_T_CRC: pos_next = POS_H_HI;
            POS_H_HI:  pos_next = POS_H_LO;
            POS_H_LO:  pos_next = POS_H_CRC;
            default:   pos_next = POS_T_HI;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= POS_T_HI;
        end else if (push) begin
            pos_reg <= pos_next;
        end
    end

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && s_tuser) |=> (pos_reg == POS_T_LO))
        else $error("frame start did not restart the byte position");

endmodule

`default_nettype wire

FILE: rtl/htfd_queue.sv
// Short queue of tagged bytes between front end and back end.
`default_nettype none

module htfd_queue
    import htfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire htfd_item_t  push_item,
    input  wire logic        pop,
    output logic             full,
    output logic             head_valid,
    output htfd_item_t       head_item
);

    htfd_item_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]         wr_ptr_reg;
    logic [Q_PTR_W-1:0]         rd_ptr_reg;
    logic [Q_CNT_W-1:0]         count_reg;
    logic [Q_CNT_W-1:0]         count_next;

    always_comb
    begin
        full       = (count_reg == Q_CNT_W'(Q_DEPTH));
        head_valid = (count_reg != '0);
        head_item  = mem_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/htfd_back.sv
// Back end: CRC check, scaling, held values and the registered result.
`default_nettype none

module htfd_back
    import htfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire htfd_item_t    head_item,
    output logic               pop,
    input  wire htfd_limits_t  limits,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata
);

    logic [7:0]  crc_reg,       crc_next;
    logic [7:0]  hi_reg,        hi_next;
    logic        temp_ok_reg,   temp_ok_next;
    logic [10:0] tenths_reg,    tenths_next;
    logic [6:0]  temp_pend_reg, temp_pend_next;
    logic [6:0]  hum_held_reg,  hum_held_next;
    logic [6:0]  temp_held_reg, temp_held_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg,  out_data_next;

    logic        out_free;
    logic        is_last;
    logic [7:0]  crc_fed;
    logic [15:0] raw;
    logic [26:0] t_prod;
    logic [27:0] t_sum;
    logic [22:0] h_prod;
    logic [23:0] h_sum;
    logic [10:0] t_round;
    logic [23:0] deg_prod;
    logic [7:0]  deg_wide;
    logic [6:0]  deg;
    logic        hum_ok;

    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        is_last  = (head_item.pos == POS_H_CRC);
        pop      = head_valid && (!is_last || out_free);

        crc_fed = crc8_feed((head_item.pos == POS_T_HI) ? CRC_INIT : crc_reg,
                            head_item.data);
        raw     = {hi_reg, head_item.data};

        // floor(x/65535) == (x + (x>>16) + 1) >> 16 for these ranges
        t_prod = 27'(raw) * 27'(TEMP_SCALE);
        t_sum  = 28'(t_prod) + 28'(t_prod[26:16]) + 28'd1;
        h_prod = 23'(raw) * 23'(HUM_SCALE);
        h_sum  = 24'(h_prod) + 24'(h_prod[22:16]) + 24'd1;

        // Round tenths half up to whole degrees; below zero reads as zero
        t_round  = tenths_reg - TEMP_OFFSET + ROUND_HALF;
        deg_prod = 24'(t_round) * 24'(RECIP_TEN);
        deg_wide = deg_prod[23:16];
        if (tenths_reg < TEMP_OFFSET) begin
            deg = 7'd0;
        end else if (deg_wide > 8'(DEG_MAX)) begin
            deg = DEG_MAX;
        end else begin
            deg = deg_wide[6:0];
        end

        hum_ok = (crc_reg == head_item.data);

        crc_next       = crc_reg;
        hi_next        = hi_reg;
        temp_ok_next   = temp_ok_reg;
        tenths_next    = tenths_reg;
        temp_pend_next = temp_pend_reg;
        hum_held_next  = hum_held_reg;
        temp_held_next = temp_held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (pop) begin
            case (head_item.pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc_next = crc_fed;
                    hi_next  = head_item.data;
                end
                POS_T_LO:
                begin
                    crc_next    = crc_fed;
                    tenths_next = t_sum[26:16];
                end
                POS_T_CRC:
                begin
                    temp_ok_next   = (crc_reg == head_item.data);
                    crc_next       = CRC_INIT;
                    temp_pend_next = deg;
                end
                POS_H_LO:
                begin
                    crc_next = crc_fed;
                    hi_next  = {1'b0, h_sum[22:16]};
                end
                default:
                begin
                    crc_next = CRC_INIT;
                    if (hum_ok) begin
                        hum_held_next = hi_reg[6:0];
                    end
                    if (temp_ok_reg) begin
                        temp_held_next = temp_pend_reg;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {temp_ok_reg, hum_ok,
                        clamp_out(temp_ok_reg ? temp_pend_reg : temp_held_reg,
                                  limits.temp_limit),
                        clamp_out(hum_ok ? hi_reg[6:0] : hum_held_reg,
                                  limits.humid_limit)};
                end
            endcase
        end

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= CRC_INIT;
            hi_reg        <= '0;
            temp_ok_reg   <= 1'b0;
            tenths_reg    <= '0;
            temp_pend_reg <= '0;
            hum_held_reg  <= '0;
            temp_held_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            hi_reg        <= hi_next;
            temp_ok_reg   <= temp_ok_next;
            tenths_reg    <= tenths_next;
            temp_pend_reg <= temp_pend_next;
            hum_held_reg  <= hum_held_next;
            temp_held_reg <= temp_held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_last) |=> m_tvalid)
        else $error("final frame byte produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(pop && is_last))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

FILE: rtl/humidity_temp_frame_decoder_core.sv
// Top level of the humidity/temperature frame decoder: config registers and wiring.
`default_nettype none

// Throughput: one byte per cycle sustained; s_tready drops only while the two-entry queue is full.
// A result shows on m_tvalid once its sixth byte, written into the queue, is popped by the back end
//   and loaded into the output register; the pop waits while the output register is still full.
// Only a frame's sixth byte waits on the output register; later bytes wait only when queued behind it.
// Reset (rst_n, asynchronous, active low): position to first byte, CRC to 0xFF, held values to 0,
//   limits to 50 degrees and 100 percent, queue and output register empty. No clearing pass.
module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire logic        s_tuser,    // [0] frame_start
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [6:0] humidity_pct, [13:7] temperature_deg,
                                         // [14] humidity_fresh, [15] temperature_fresh
    // Register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    htfd_limits_t limits_reg;
    logic         q_full;
    logic         push;
    htfd_item_t   push_item;
    logic         pop;
    logic         head_valid;
    htfd_item_t   head_item;

    // Register writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limits_reg.temp_limit  <= TEMP_LIMIT_RST;
            limits_reg.humid_limit <= HUMID_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TEMP_LIMIT:  limits_reg.temp_limit  <= cfg_data;
                CFG_HUMID_LIMIT: limits_reg.humid_limit <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Front end: track frame position, tag each byte
    htfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Hold tagged bytes so front and back stall independently
    htfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: check CRC, scale words, commit held values, emit result
    htfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .limits     (limits_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/tb_humidity_temp_frame_decoder_core.sv
// Self-checking testbench for the humidity/temperature frame decoder core.
module tb_humidity_temp_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    // One decoded reading as it leaves the block, field order matches m_tdata
    typedef struct packed {
        logic       temp_fresh;
        logic       hum_fresh;
        logic [6:0] temp_deg;
        logic [6:0] hum_pct;
    } reading_t;

    // Tracks the frame decoding of every accepted byte and keeps the readings
    // that the block owes us, oldest first.
    class reading_scoreboard;
        logic [6:0] temp_limit;
        logic [6:0] hum_limit;
        logic [2:0] byte_pos;
        logic [7:0] crc;
        logic [7:0] hi_or_hum;   // high byte of a word, then scaled humidity
        logic       temp_ok;
        logic [6:0] temp_new;
        logic [6:0] hum_held;
        logic [6:0] temp_held;
        reading_t   owed[$];
        int         errors;

        function new();
            temp_limit = TEMP_LIMIT_RST;
            hum_limit  = HUMID_LIMIT_RST;
            byte_pos   = 3'd0;
            crc        = 8'hFF;
            hi_or_hum  = 8'd0;
            temp_ok    = 1'b0;
            temp_new   = 7'd0;
            hum_held   = 7'd0;
            temp_held  = 7'd0;
            errors     = 0;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            repeat (8) r = r[7] ? ((r << 1) ^ 8'h31) : (r << 1);
            return r;
        endfunction

        static function logic [6:0] humidity_of(logic [15:0] raw);
            int unsigned prod;
            prod = 100 * raw;
            return 7'(prod / 65535);
        endfunction

        static function logic [6:0] degrees_of(logic [15:0] raw);
            int unsigned prod;
            int          tenths;
            int          deg;
            prod   = 1750 * raw;
            tenths = int'(prod / 65535) - 450;
            if (tenths < 0)
                return 7'd0;
            deg = tenths / 10;
            if (tenths % 10 >= 5)
                deg++;
            if (deg > 127)
                deg = 127;
            return 7'(deg);
        endfunction

        static function logic [6:0] report(logic [6:0] v, logic [6:0] lim);
            logic [6:0] l;
            logic [6:0] x;
            l = (lim == 7'd0) ? 7'd1 : lim;
            x = (v == 7'd0) ? 7'd1 : v;
            return (x > l) ? l : x;
        endfunction

        function void set_limit(cfg_index_t idx, logic [6:0] v);
            if (idx == CFG_TEMP_LIMIT)
                temp_limit = v;
            else if (idx == CFG_HUMID_LIMIT)
                hum_limit = v;
        endfunction

        // Advance the frame state by one accepted byte; owe a reading after byte six.
        function void note_byte(logic [7:0] b, logic start);
            pos_t     pos;
            logic     hum_ok;
            reading_t r;
            if (start || byte_pos > 3'd5) begin
                byte_pos = 3'd0;
                crc = 8'hFF;
            end
            pos = pos_t'(byte_pos);
            byte_pos = byte_pos + 3'd1;
            case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc = crc_step(crc, b);
                    hi_or_hum = b;
                end
                POS_T_LO:
                begin
                    crc = crc_step(crc, b);
                    temp_new = degrees_of({hi_or_hum, b});
                end
                POS_T_CRC:
                begin
                    temp_ok = (crc == b);
                    crc = 8'hFF;
                end
                POS_H_LO:
                begin
                    crc = crc_step(crc, b);
                    hi_or_hum = {1'b0, humidity_of({hi_or_hum, b})};
                end
                default:
                begin
                    hum_ok = (crc == b);
                    crc = 8'hFF;
                    if (hum_ok)
                        hum_held = hi_or_hum[6:0];
                    if (temp_ok)
                        temp_held = temp_new;
                    r.hum_pct    = report(hum_held, hum_limit);
                    r.temp_deg   = report(temp_held, temp_limit);
                    r.hum_fresh  = hum_ok;
                    r.temp_fresh = temp_ok;
                    owed.push_back(r);
                    byte_pos = 3'd0;
                end
            endcase
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: reading with none owed: hum %0d temp %0d fresh %b%b",
                             $realtime, got.hum_pct, got.temp_deg, got.hum_fresh,
                             got.temp_fresh);
                return;
            end
            want = owed.pop_front();
            if (got.hum_pct != want.hum_pct || got.temp_deg != want.temp_deg ||
                got.hum_fresh != want.hum_fresh || got.temp_fresh != want.temp_fresh) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: reading differs: hum %0d/%0d temp %0d/%0d %s %b/%b %s %b/%b",
                             $realtime, want.hum_pct, got.hum_pct, want.temp_deg,
                             got.temp_deg, "hum fresh", want.hum_fresh, got.hum_fresh,
                             "temp fresh", want.temp_fresh, got.temp_fresh);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] rx_byte
    logic        s_tuser = 1'b0;     // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [6:0] humidity_pct, [13:7] temperature_deg,
                                     // [14] humidity_fresh, [15] temperature_fresh
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [6:0]  cfg_data = 7'd0;

    // Set during a phase that runs both sides at full rate
    bit                quiet = 1'b0;
    reading_scoreboard sb = new();

    humidity_temp_frame_decoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watch both streams at the rising edge; values seen here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(reading_t'(m_tdata));
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Receiver: bursts of ready broken by stalls
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(1, 20))
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            repeat (pick_gap())
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
        end
    end

    // Present one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic start);
        repeat (pick_gap())
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Send the first n bytes of a frame; a bad flag corrupts that word's check byte
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input bit t_bad, input bit h_bad, input bit mark,
                              input int unsigned n_bytes);
        logic [7:0] fb[6];
        fb[0] = t_raw[15:8];
        fb[1] = t_raw[7:0];
        fb[2] = reading_scoreboard::crc_step(reading_scoreboard::crc_step(8'hFF, fb[0]), fb[1]);
        fb[3] = h_raw[15:8];
        fb[4] = h_raw[7:0];
        fb[5] = reading_scoreboard::crc_step(reading_scoreboard::crc_step(8'hFF, fb[3]), fb[4]);
        if (t_bad)
            fb[2] ^= 8'($urandom_range(1, 255));
        if (h_bad)
            fb[5] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < n_bytes; i++)
            send_byte(fb[i], mark && i == 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [6:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait out every owed reading, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_raw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h0000;
        if (r < 16)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly well-formed frames with random words, some broken frames and loose bytes
    task automatic random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned r;
        int unsigned k;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 5) == 0,
                           $urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0, 6);
                sent += 6;
            end
            else if (r < 88) begin
                k = $urandom_range(1, 5);
                send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, k);
                sent += k;
            end
            else begin
                k = $urandom_range(1, 6);
                repeat (k) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += k;
            end
        end
    endtask

    initial
    begin
        logic [6:0] t_lims[5];
        logic [6:0] h_lims[5];
        t_lims = '{7'd127, 7'd0, 7'd1, 7'd0, 7'd0};
        h_lims = '{7'd127, 7'd0, 7'd1, 7'd0, 7'd0};
        t_lims[3] = 7'($urandom_range(1, 127));
        h_lims[3] = 7'($urandom_range(1, 100));
        t_lims[4] = 7'($urandom_range(0, 127));
        h_lims[4] = 7'($urandom_range(0, 127));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limits: hottest and wettest words, temperature saturates
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
        // No start mark: position wraps; zero words report as 1
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
        // Frame cut short, then restarted by a new start mark
        send_frame(16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 2);
        // Temperature exactly on a half degree, humidity check byte wrong
        send_frame(16'd26402, 16'h8000, 1'b0, 1'b1, 1'b1, 6);
        // Temperature check byte wrong, held temperature stays
        send_frame(16'h4000, 16'h0001, 1'b1, 1'b0, 1'b1, 6);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(CFG_TEMP_LIMIT, t_lims[ph]);
            write_reg(CFG_HUMID_LIMIT, h_lims[ph]);
            quiet = (ph == 2);
            random_traffic(270);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
